// File: rtl/core/bpe_seg_pkg.sv
// ----------------------------------------------------------------------------
// bpe_seg_pkg
// Types, character codes and class codes shared by the pretokenizer segmenter.
// ----------------------------------------------------------------------------
package bpe_seg_pkg;

  localparam logic [2:0] CLS_LETTER = 3'd0;
  localparam logic [2:0] CLS_DIGIT  = 3'd1;
  localparam logic [2:0] CLS_OTHER  = 3'd2;
  localparam logic [2:0] CLS_SPACE  = 3'd3;
  localparam logic [2:0] CLS_CONTR  = 3'd4;

  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_HIGH  = 8'h80;

  // Bytes still visible from the decided byte on: one, two, or three and more
  localparam logic [1:0] AVAIL_ONE   = 2'd1;
  localparam logic [1:0] AVAIL_TWO   = 2'd2;
  localparam logic [1:0] AVAIL_THREE = 2'd3;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef struct packed {
    logic [7:0] cur_byte;
    logic [7:0] nxt1;
    logic [7:0] nxt2;
    logic [1:0] avail;
    logic       text_last;
    logic       run_last;
  } seg_entry_t;

  function automatic logic [2:0] classify(input logic [7:0] b);
    logic [2:0] c;
    if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b >= CH_HIGH) begin
      c = CLS_LETTER;
    end else if (b >= "0" && b <= "9") begin
      c = CLS_DIGIT;
    end else if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR ||
                 b == CH_VT || b == CH_FF) begin
      c = CLS_SPACE;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/bpe_seg_in_if.sv
// ----------------------------------------------------------------------------
// bpe_seg_in_if
// Text byte channel: valid/ready handshake with byte and end flag.
// ----------------------------------------------------------------------------
interface bpe_seg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

// File: rtl/core/bpe_seg_out_if.sv
// ----------------------------------------------------------------------------
// bpe_seg_out_if
// Segmented byte channel: valid/ready handshake with byte and piece tags.
// ----------------------------------------------------------------------------
interface bpe_seg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       piece_start;
  logic [2:0] piece_class;
  logic       text_last;
  logic       run_last;

  modport source (output valid, output out_byte, output piece_start, output piece_class,
                  output text_last, output run_last, input ready);
  modport sink   (input valid, input out_byte, input piece_start, input piece_class,
                  input text_last, input run_last, output ready);
endinterface

// File: rtl/core/bpe_seg_front.sv
// ----------------------------------------------------------------------------
// bpe_seg_front
// Lookahead window: holds three bytes (four at text end), emits one entry
// per decided byte; drains at text end, one per cycle while queue not full.
// ----------------------------------------------------------------------------
module bpe_seg_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  bpe_seg_in_if.sink              text_i,
  output logic                    push_o,
  output bpe_seg_pkg::seg_entry_t entry_o,
  input  logic                    full_i
);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_FLUSH = 2'b10
  } front_state_e;

  front_state_e state_q, state_d;
  logic [7:0]   win_q [4];
  logic [7:0]   win_d [4];
  logic [2:0]   cnt_q, cnt_d;
  logic         accept;

  assign text_i.ready = (state_q == ST_RUN) && !full_i;
  assign accept       = text_i.valid && text_i.ready;

  always_comb begin
    state_d = state_q;
    win_d   = win_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    entry_o.cur_byte  = win_q[0];
    entry_o.nxt1      = win_q[1];
    entry_o.nxt2      = win_q[2];
    entry_o.avail     = bpe_seg_pkg::AVAIL_THREE;
    entry_o.text_last = 1'b0;
    entry_o.run_last  = 1'b1;
    case (state_q)
      ST_RUN: begin
        if (accept) begin
          if (text_i.text_end) begin
            win_d[cnt_q[1:0]] = text_i.text_byte;
            cnt_d   = cnt_q + 3'd1;
            state_d = ST_FLUSH;
          end else if (cnt_q == 3'd3) begin
            push_o   = 1'b1;
            win_d[0] = win_q[1];
            win_d[1] = win_q[2];
            win_d[2] = text_i.text_byte;
          end else begin
            win_d[cnt_q[1:0]] = text_i.text_byte;
            cnt_d = cnt_q + 3'd1;
          end
        end
      end
      ST_FLUSH: begin
        entry_o.avail     = (cnt_q >= 3'd3) ? bpe_seg_pkg::AVAIL_THREE : cnt_q[1:0];
        entry_o.text_last = (cnt_q == 3'd1);
        entry_o.run_last  = (cnt_q == 3'd1);
        if (!full_i) begin
          push_o   = 1'b1;
          win_d[0] = win_q[1];
          win_d[1] = win_q[2];
          win_d[2] = win_q[3];
          cnt_d    = cnt_q - 3'd1;
          if (cnt_q == 3'd1) begin
            state_d = ST_RUN;
          end
        end
      end
      default: begin
        state_d = ST_RUN;
        cnt_d   = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

// File: rtl/core/bpe_seg_queue.sv
// ----------------------------------------------------------------------------
// bpe_seg_queue
// Short FIFO of window entries between the front and the back.
// ----------------------------------------------------------------------------
module bpe_seg_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  bpe_seg_pkg::seg_entry_t entry_i,
  output logic                    full_o,
  output logic                    avail_o,
  input  logic                    pop_i,
  output bpe_seg_pkg::seg_entry_t entry_o
);

  localparam int unsigned PtrW = bpe_seg_pkg::QueuePtrW;
  localparam int unsigned CntW = PtrW + 1;

  bpe_seg_pkg::seg_entry_t mem_q [bpe_seg_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(bpe_seg_pkg::QueueDepth));
  assign avail_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// File: rtl/core/bpe_seg_back.sv
// ----------------------------------------------------------------------------
// bpe_seg_back
// Piece decision and output register: one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
module bpe_seg_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    avail_i,
  input  bpe_seg_pkg::seg_entry_t entry_i,
  output logic                    pop_o,
  bpe_seg_out_if.source           piece_o
);

  logic [2:0] cur_cls_q, cur_cls_d;
  logic       open_q, open_d;
  logic [1:0] contr_q, contr_d;
  logic       lead_q, lead_d;
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       start_q, start_d;
  logic [2:0] cls_q, cls_d;
  logic       tlast_q, rlast_q;
  logic [2:0] cls_b, cls_n1;
  logic       apos, two, three;
  logic [7:0] b, n1, n2;

  assign pop_o = avail_i && (!out_valid_q || piece_o.ready);
  assign b     = entry_i.cur_byte;
  assign n1    = entry_i.nxt1;
  assign n2    = entry_i.nxt2;
  assign cls_b  = bpe_seg_pkg::classify(b);
  assign cls_n1 = bpe_seg_pkg::classify(n1);
  assign apos  = (b == bpe_seg_pkg::CH_APOS) && (entry_i.avail != bpe_seg_pkg::AVAIL_ONE);
  assign two   = (n1 == "s") || (n1 == "t") || (n1 == "m") || (n1 == "d");
  assign three = (entry_i.avail == bpe_seg_pkg::AVAIL_THREE) &&
                 (((n1 == "r") && (n2 == "e")) || ((n1 == "v") && (n2 == "e")) ||
                  ((n1 == "l") && (n2 == "l")));

  always_comb begin
    cur_cls_d = cur_cls_q;
    open_d    = open_q;
    contr_d   = contr_q;
    lead_d    = lead_q;
    start_d   = 1'b0;
    cls_d     = cur_cls_q;
    if (contr_q != 2'd0) begin
      contr_d = contr_q - 2'd1;
      cls_d   = bpe_seg_pkg::CLS_CONTR;
    end else if (open_q && lead_q) begin
      lead_d = 1'b0;
    end else if (open_q && (cur_cls_q != bpe_seg_pkg::CLS_CONTR) && (cls_b == cur_cls_q)) begin
      cls_d = cur_cls_q;
    end else begin
      start_d = 1'b1;
      lead_d  = 1'b0;
      if (apos && two) begin
        cls_d   = bpe_seg_pkg::CLS_CONTR;
        contr_d = 2'd1;
      end else if (apos && three) begin
        cls_d   = bpe_seg_pkg::CLS_CONTR;
        contr_d = 2'd2;
      end else if ((b == bpe_seg_pkg::CH_SPACE) && (entry_i.avail != bpe_seg_pkg::AVAIL_ONE) &&
                   (cls_n1 != bpe_seg_pkg::CLS_SPACE)) begin
        cls_d  = cls_n1;
        lead_d = 1'b1;
      end else begin
        cls_d = cls_b;
      end
      cur_cls_d = cls_d;
      open_d    = 1'b1;
    end
    // end of text: piece state back to its reset values
    if (entry_i.text_last) begin
      cur_cls_d = bpe_seg_pkg::CLS_LETTER;
      open_d    = 1'b0;
      contr_d   = 2'd0;
      lead_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_cls_q   <= bpe_seg_pkg::CLS_LETTER;
      open_q      <= 1'b0;
      contr_q     <= 2'd0;
      lead_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_cls_q   <= cur_cls_d;
        open_q      <= open_d;
        contr_q     <= contr_d;
        lead_q      <= lead_d;
        out_valid_q <= 1'b1;
      end else if (piece_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q  <= b;
      start_q <= start_d;
      cls_q   <= cls_d;
      tlast_q <= entry_i.text_last;
      rlast_q <= entry_i.run_last;
    end
  end

  assign piece_o.valid       = out_valid_q;
  assign piece_o.out_byte    = byte_q;
  assign piece_o.piece_start = start_q;
  assign piece_o.piece_class = cls_q;
  assign piece_o.text_last   = tlast_q;
  assign piece_o.run_last    = rlast_q;

endmodule

// File: rtl/core/bpe_pretokenizer_segmenter.sv
// ----------------------------------------------------------------------------
// bpe_pretokenizer_segmenter
// Splits a byte stream into pieces and tags every byte with a piece-start
// flag and a class, three bytes behind the input.
//
//   channel   dir  payload                                          handshake
//   text_i    in   text_byte[7:0], text_end                         valid/ready
//   piece_o   out  out_byte[7:0], piece_start, piece_class[2:0],    valid/ready
//                  text_last, run_last
//
// One byte per cycle in steady flow; a byte is presented once the third byte
// behind it is accepted, its entry having passed queue and output register.
// A byte with text_end set drains the lookahead window: the front takes no
// new byte until every byte held in the window has been pushed to the queue.
// A four-entry queue separates the window from the decision stage; while a
// result waits in the output register the back holds, and the input stalls
// once the queue is full.
// Reset clears the window count, piece state, queue and output valid.
// ----------------------------------------------------------------------------
module bpe_pretokenizer_segmenter (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpe_seg_in_if.sink    text_i,
  bpe_seg_out_if.source piece_o
);

  bpe_seg_pkg::seg_entry_t front_entry, back_entry;
  logic front_push, q_full, q_avail, back_pop;

  bpe_seg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_i),
    .push_o  (front_push),
    .entry_o (front_entry),
    .full_i  (q_full)
  );

  bpe_seg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .avail_o (q_avail),
    .pop_i   (back_pop),
    .entry_o (back_entry)
  );

  bpe_seg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (q_avail),
    .entry_i (back_entry),
    .pop_o   (back_pop),
    .piece_o (piece_o)
  );

endmodule

// File: rtl/core/bpe_seg_chk.sv
// ----------------------------------------------------------------------------
// bpe_seg_chk
// Port-level checks on the segmenter output, bound to the top level.
// ----------------------------------------------------------------------------
module bpe_seg_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic [7:0] out_byte_i,
  input logic       piece_start_i,
  input logic [2:0] piece_class_i,
  input logic       text_last_i,
  input logic       run_last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(out_byte_i) && $stable(piece_class_i) &&
                            $stable(piece_start_i) && $stable(text_last_i))
    else $error("output changed while stalled");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && text_last_i |-> run_last_i)
    else $error("text end without run end");

  a_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> piece_class_i <= bpe_seg_pkg::CLS_CONTR)
    else $error("piece class out of range");

  a_contr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && piece_start_i && (piece_class_i == bpe_seg_pkg::CLS_CONTR)
      |-> out_byte_i == bpe_seg_pkg::CH_APOS)
    else $error("contraction does not start with apostrophe");

endmodule

bind bpe_pretokenizer_segmenter bpe_seg_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (piece_o.valid),
  .ready_i       (piece_o.ready),
  .out_byte_i    (piece_o.out_byte),
  .piece_start_i (piece_o.piece_start),
  .piece_class_i (piece_o.piece_class),
  .text_last_i   (piece_o.text_last),
  .run_last_i    (piece_o.run_last)
);
